### hw/rtl/clle_pkg.sv
// shared types and codes for the cursor linked list engine
`default_nettype none

package clle_pkg;

  // request opcodes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // input transaction payload
  typedef struct packed {
    op_t        opcode;
    logic [7:0] position;
    logic [7:0] element;
  } request_t;

  // output transaction payload
  typedef struct packed {
    status_t    status;
    logic [7:0] read_value;
    logic [7:0] list_length;
  } result_t;

  // link memory read address source
  typedef enum logic [1:0] {
    RA_ZERO = 2'd0,
    RA_CUR  = 2'd1,
    RA_DATA = 2'd2
  } rd_addr_sel_t;

  // link memory write address source
  typedef enum logic [1:0] {
    WA_ZERO  = 2'd0,
    WA_CUR   = 2'd1,
    WA_SLOT  = 2'd2,
    WA_SWEEP = 2'd3
  } wr_addr_sel_t;

  // link memory write data source
  typedef enum logic [1:0] {
    WD_DATA = 2'd0,
    WD_SLOT = 2'd1,
    WD_INIT = 2'd2
  } wr_data_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic         req_load;
    rd_addr_sel_t rd_addr_sel;
    logic         cur_from_data;
    logic         walk_init;
    logic         rem_dec;
    logic         slot_load;
    logic         wr_en;
    wr_addr_sel_t wr_addr_sel;
    wr_data_sel_t wr_data_sel;
    logic         val_wr;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         cnt_clr;
    logic         sweep_clr;
    logic         sweep_inc;
    logic         finish;
    status_t      fin_status;
    logic         fin_read;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_t  opcode;
    logic ins_pos_ok;
    logic acc_pos_ok;
    logic data_zero;
    logic walk_done;
    logic sweep_last;
  } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/cursor_linked_list_engine.sv
// top level: ordered byte list kept as linked slots in a cursor array
// one list link is followed per cycle through the link memory
// requests are taken one at a time, only while busy is low
// reset: link memory is swept to the free chain while busy is high
// the result is shown one cycle on result with done; the receiver cannot stall
`default_nettype none

module cursor_linked_list_engine #(
  parameter int SLOT_COUNT = 256
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  clle_pkg::request_t  request,
  output logic                done,
  output clle_pkg::result_t   result
);
  import clle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  clle_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // storage and arithmetic
  clle_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

`default_nettype wire

### hw/rtl/clle_dp.sv
// datapath: link and value memories, walk cursor, element count, result register
`default_nettype none

module clle_dp #(
  parameter int SLOT_COUNT = 256
) (
  input  wire                 clk,
  input  wire                 rst,
  input  clle_pkg::request_t  request,
  input  clle_pkg::dp_cmd_t   cmd,
  output clle_pkg::dp_stat_t  stat,
  output logic                done,
  output clle_pkg::result_t   result
);
  import clle_pkg::*;

  localparam int AW   = $clog2(SLOT_COUNT);
  localparam int LW   = (AW > 8) ? AW : 8;
  localparam int CMPW = LW + 1;
  localparam logic [AW-1:0] HEAD      = AW'(SLOT_COUNT - 1);
  localparam logic [AW-1:0] LAST_FREE = AW'(SLOT_COUNT - 2);

  logic [AW-1:0] link_mem [SLOT_COUNT];
  logic [7:0]    val_mem  [SLOT_COUNT];

  request_t      req;
  logic [AW-1:0] cur;
  logic [AW-1:0] slot;
  logic [AW-1:0] sweep_idx;
  logic [7:0]    rem;
  logic [AW-1:0] cnt;
  logic [AW-1:0] cnt_next;
  logic [AW-1:0] link_q;
  logic [7:0]    val_q;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] wr_data;
  logic [AW-1:0] init_data;
  logic [CMPW-1:0] pos_w;
  logic [CMPW-1:0] cnt_w;
  logic [LW-1:0]   cnt_ext;
  logic [7:0]      len_sat;

  // read address select
  always_comb begin
    case (cmd.rd_addr_sel)
      RA_ZERO: rd_addr = '0;
      RA_CUR:  rd_addr = cur;
      RA_DATA: rd_addr = link_q;
      default: rd_addr = '0;
    endcase
  end

  // reset chain value for the sweep slot
  assign init_data = (sweep_idx < LAST_FREE) ? AW'(sweep_idx + 1'b1) : '0;

  // write address and data select
  always_comb begin
    case (cmd.wr_addr_sel)
      WA_ZERO:  wr_addr = '0;
      WA_CUR:   wr_addr = cur;
      WA_SLOT:  wr_addr = slot;
      WA_SWEEP: wr_addr = sweep_idx;
      default:  wr_addr = '0;
    endcase
    case (cmd.wr_data_sel)
      WD_DATA: wr_data = link_q;
      WD_SLOT: wr_data = slot;
      WD_INIT: wr_data = init_data;
      default: wr_data = '0;
    endcase
  end

  // link memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    link_q <= link_mem[rd_addr];
  end

  // value memory, read alongside the link memory
  always_ff @(posedge clk) begin
    if (cmd.val_wr) begin
      val_mem[slot] <= req.element;
    end
    val_q <= val_mem[rd_addr];
  end

  // request latch, cursor, popped slot, walk step counter
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req <= request;
    end
    if (cmd.walk_init) begin
      cur <= HEAD;
    end else if (cmd.cur_from_data) begin
      cur <= link_q;
    end
    if (cmd.slot_load) begin
      slot <= link_q;
    end
    if (cmd.walk_init) begin
      rem <= (req.opcode == OP_READ) ? req.position : req.position - 8'd1;
    end else if (cmd.rem_dec) begin
      rem <= rem - 8'd1;
    end
  end

  // element count
  always_comb begin
    cnt_next = cnt;
    if (cmd.cnt_clr) begin
      cnt_next = '0;
    end else if (cmd.cnt_inc) begin
      cnt_next = cnt + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt_next = cnt - 1'b1;
    end
  end

  // count and sweep index are control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      sweep_idx <= '0;
    end else begin
      cnt <= cnt_next;
      if (cmd.sweep_clr) begin
        sweep_idx <= '0;
      end else if (cmd.sweep_inc) begin
        sweep_idx <= sweep_idx + 1'b1;
      end
    end
  end

  // position range checks
  assign pos_w = CMPW'(req.position);
  assign cnt_w = CMPW'(cnt);

  assign stat.opcode     = req.opcode;
  assign stat.ins_pos_ok = (req.position != 8'd0) && (pos_w <= cnt_w + CMPW'(1));
  assign stat.acc_pos_ok = (req.position != 8'd0) && (pos_w <= cnt_w);
  assign stat.data_zero  = (link_q == '0);
  assign stat.walk_done  = (rem == 8'd0);
  assign stat.sweep_last = (sweep_idx == HEAD);

  // saturate length to eight bits
  assign cnt_ext = LW'(cnt_next);
  assign len_sat = (cnt_ext > LW'(8'hFF)) ? 8'hFF : cnt_ext[7:0];

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.status      <= cmd.fin_status;
      result.read_value  <= cmd.fin_read ? val_q : 8'd0;
      result.list_length <= len_sat;
    end
  end

  // count never exceeds the usable slots
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= LAST_FREE)
    else $error("element count above capacity");

  // the result strobe is never held high
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held");

  // count moves by one per finished insert or delete
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_inc || cmd.cnt_dec) |-> cmd.finish)
    else $error("count changed outside a finishing step");

endmodule

`default_nettype wire

### hw/rtl/clle_ctrl.sv
// controller: sequences decode, free chain pops and pushes, list walks, reset and clearing sweeps
`default_nettype none

module clle_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  clle_pkg::dp_stat_t stat,
  output clle_pkg::dp_cmd_t  cmd
);
  import clle_pkg::*;

  typedef enum logic [14:0] {
    S_INIT       = 15'h0001,
    S_IDLE       = 15'h0002,
    S_DECODE     = 15'h0004,
    S_INS_FREE   = 15'h0008,
    S_INS_POP    = 15'h0010,
    S_WALK_FIRST = 15'h0020,
    S_WALK       = 15'h0040,
    S_INS_LINK   = 15'h0080,
    S_INS_TAIL   = 15'h0100,
    S_DEL_SUCC   = 15'h0200,
    S_DEL_UNLINK = 15'h0400,
    S_DEL_FREE   = 15'h0800,
    S_DEL_HEAD   = 15'h1000,
    S_READ_VAL   = 15'h2000,
    S_CLEAR      = 15'h4000
  } state_t;

  state_t state;
  state_t state_next;
  state_t post_walk;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // where a finished walk continues
  always_comb begin
    case (stat.opcode)
      OP_INSERT: post_walk = S_INS_LINK;
      OP_DELETE: post_walk = S_DEL_SUCC;
      default:   post_walk = S_READ_VAL;
    endcase
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_SWEEP;
        cmd.wr_data_sel = WD_INIT;
        cmd.sweep_inc   = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.req_load = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.opcode)
          OP_INSERT: begin
            if (stat.ins_pos_ok) begin
              cmd.rd_addr_sel = RA_ZERO;
              state_next      = S_INS_FREE;
            end else begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_BAD_POS;
              state_next     = S_IDLE;
            end
          end
          OP_DELETE, OP_READ: begin
            if (stat.acc_pos_ok) begin
              cmd.walk_init = 1'b1;
              state_next    = S_WALK_FIRST;
            end else begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_BAD_POS;
              state_next     = S_IDLE;
            end
          end
          OP_CLEAR: begin
            cmd.sweep_clr = 1'b1;
            state_next    = S_CLEAR;
          end
          default: state_next = S_IDLE;
        endcase
      end
      // head of the free chain is in the read register
      S_INS_FREE: begin
        if (stat.data_zero) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_FULL;
          state_next     = S_IDLE;
        end else begin
          cmd.slot_load   = 1'b1;
          cmd.rd_addr_sel = RA_DATA;
          state_next      = S_INS_POP;
        end
      end
      // unhook the popped slot and store its value
      S_INS_POP: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_ZERO;
        cmd.wr_data_sel = WD_DATA;
        cmd.val_wr      = 1'b1;
        cmd.walk_init   = 1'b1;
        state_next      = S_WALK_FIRST;
      end
      S_WALK_FIRST: begin
        cmd.rd_addr_sel = RA_CUR;
        if (stat.walk_done) begin
          state_next = post_walk;
        end else begin
          cmd.rem_dec = 1'b1;
          state_next  = S_WALK;
        end
      end
      // one link followed per cycle
      S_WALK: begin
        cmd.rd_addr_sel   = RA_DATA;
        cmd.cur_from_data = 1'b1;
        if (stat.walk_done) begin
          state_next = post_walk;
        end else begin
          cmd.rem_dec = 1'b1;
        end
      end
      S_INS_LINK: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_SLOT;
        cmd.wr_data_sel = WD_DATA;
        state_next      = S_INS_TAIL;
      end
      S_INS_TAIL: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_CUR;
        cmd.wr_data_sel = WD_SLOT;
        cmd.cnt_inc     = 1'b1;
        cmd.finish      = 1'b1;
        cmd.fin_status  = ST_OK;
        state_next      = S_IDLE;
      end
      S_DEL_SUCC: begin
        cmd.slot_load   = 1'b1;
        cmd.rd_addr_sel = RA_DATA;
        state_next      = S_DEL_UNLINK;
      end
      S_DEL_UNLINK: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_CUR;
        cmd.wr_data_sel = WD_DATA;
        cmd.rd_addr_sel = RA_ZERO;
        state_next      = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_SLOT;
        cmd.wr_data_sel = WD_DATA;
        state_next      = S_DEL_HEAD;
      end
      S_DEL_HEAD: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_ZERO;
        cmd.wr_data_sel = WD_SLOT;
        cmd.cnt_dec     = 1'b1;
        cmd.finish      = 1'b1;
        cmd.fin_status  = ST_OK;
        state_next      = S_IDLE;
      end
      S_READ_VAL: begin
        cmd.finish     = 1'b1;
        cmd.fin_status = ST_OK;
        cmd.fin_read   = 1'b1;
        state_next     = S_IDLE;
      end
      S_CLEAR: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_SWEEP;
        cmd.wr_data_sel = WD_INIT;
        cmd.sweep_inc   = 1'b1;
        if (stat.sweep_last) begin
          cmd.cnt_clr    = 1'b1;
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_OK;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory is never written while waiting for a request
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !cmd.wr_en)
    else $error("link write while idle");

  // reset always starts the initial sweep
  a_reset_busy: assert property (@(posedge clk)
    rst |=> busy)
    else $error("not busy after reset");

  // a full status only comes from an insert, right after the free chain head was read
  a_full_src: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && cmd.fin_status == ST_FULL) |-> stat.opcode == OP_INSERT)
    else $error("full status outside insert");

endmodule

`default_nettype wire

### tb/cursor_linked_list_engine_tb.sv
// self-checking testbench for the cursor linked list engine
`timescale 1ns / 100ps

module cursor_linked_list_engine_tb;
  import clle_pkg::*;

  localparam int SLOTS = 256;
  localparam int MAX_HELD = SLOTS - 2;
  localparam int RANDOM_ITEMS = 900;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  // bias of the random request mix
  typedef enum {TILT_GROW, TILT_SHRINK, TILT_MIXED} tilt_t;

  // shadow copy of the slot store that predicts each result
  class list_shadow;
    logic [7:0] link_of[SLOTS];
    logic [7:0] byte_at[SLOTS];
    int held;
    result_t awaited[$];
    int errors;

    function new();
      foreach (byte_at[i]) byte_at[i] = '0;
      errors = 0;
      restore_chain();
    endfunction

    // every slot on the free chain, list empty; values are kept
    function void restore_chain();
      for (int i = 0; i < SLOTS - 2; i++) link_of[i] = 8'(i + 1);
      link_of[SLOTS-2] = '0;
      link_of[SLOTS-1] = '0;
      held = 0;
    endfunction

    // follow the list from its head slot
    function int follow(int steps);
      int at;
      at = SLOTS - 1;
      repeat (steps) at = link_of[at];
      return at;
    endfunction

    // apply an accepted transaction and queue the result it should give
    function void note_request(request_t req);
      result_t want;
      int pos, fresh, prev, gone;
      pos = req.position;
      want.status = ST_OK;
      want.read_value = '0;
      case (req.opcode)
        OP_INSERT: begin
          if (pos < 1 || pos > held + 1) begin
            want.status = ST_BAD_POS;
          end else if (link_of[0] == 0) begin
            want.status = ST_FULL;
          end else begin
            fresh = link_of[0];
            link_of[0] = link_of[fresh];
            byte_at[fresh] = req.element;
            prev = follow(pos - 1);
            link_of[fresh] = link_of[prev];
            link_of[prev] = 8'(fresh);
            held++;
          end
        end
        OP_DELETE: begin
          if (pos < 1 || pos > held) begin
            want.status = ST_BAD_POS;
          end else begin
            prev = follow(pos - 1);
            gone = link_of[prev];
            link_of[prev] = link_of[gone];
            link_of[gone] = link_of[0];
            link_of[0] = 8'(gone);
            held--;
          end
        end
        OP_READ: begin
          if (pos < 1 || pos > held) want.status = ST_BAD_POS;
          else want.read_value = byte_at[follow(pos)];
        end
        default: begin
          restore_chain();
        end
      endcase
      want.list_length = (held > 255) ? 8'd255 : 8'(held);
      awaited.push_back(want);
    endfunction

    // compare a result transaction with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got status %0d read_value %0d length %0d",
                 $time, got.status, got.read_value, got.list_length);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      end
      if (got.read_value !== want.read_value) begin
        errors++;
        $display("%0t: read_value expected %0d, got %0d", $time, want.read_value,
                 got.read_value);
      end
      if (got.list_length !== want.list_length) begin
        errors++;
        $display("%0t: list_length expected %0d, got %0d", $time, want.list_length,
                 got.list_length);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  request_t request = '0;
  logic done;
  result_t result;

  list_shadow shadow;
  bit no_gaps = 1'b0;
  int sent = 0;
  int idle_cycles = 0;

  cursor_linked_list_engine #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sample both sides of the block at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) shadow.check_result(result);
      if (start && !busy) shadow.note_request(request);
    end
  end

  // stall watchdog: no transaction in either direction for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one request after a random gap and hold it until accepted
  task automatic issue(op_t op, int pos, int elem);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    request = '{opcode: op, position: pos[7:0], element: elem[7:0]};
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
  endtask

  // request in range for the current list (clear: any position); delete or read on an empty list becomes an insert
  task automatic issue_valid(op_t op);
    int n;
    n = shadow.held;
    if (op == OP_CLEAR)
      issue(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
    else if (op == OP_INSERT || n == 0)
      issue(OP_INSERT, $urandom_range(1, n + 1), $urandom_range(0, 255));
    else
      issue(op, $urandom_range(1, n), $urandom_range(0, 255));
  endtask

  initial begin
    tilt_t tilt;
    int left_in_phase, roll, random_start;
    bit filled;
    shadow = new();
    tilt = TILT_MIXED;
    left_in_phase = 0;
    filled = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty list, ends of the list, bad positions, clear
    issue(OP_READ, 1, 0);
    issue(OP_DELETE, 1, 0);
    issue(OP_INSERT, 0, 8'h11);
    issue(OP_INSERT, 2, 8'h22);
    issue(OP_INSERT, 1, 8'hFF);
    issue(OP_INSERT, 1, 8'h00);
    issue(OP_INSERT, 3, 8'hA5);
    issue(OP_INSERT, 2, 8'h5A);
    issue(OP_READ, 1, 8'hFF);
    issue(OP_READ, 4, 0);
    issue(OP_READ, 2, 0);
    issue(OP_READ, 5, 0);
    issue(OP_READ, 0, 0);
    issue(OP_DELETE, 5, 0);
    issue(OP_DELETE, 0, 0);
    issue(OP_DELETE, 4, 0);
    issue(OP_DELETE, 1, 0);
    issue(OP_INSERT, 255, 8'h77);
    issue(OP_READ, 255, 0);
    issue(OP_READ, 2, 0);
    issue(OP_CLEAR, 1, 0);
    issue(OP_READ, 1, 0);
    issue(OP_INSERT, 1, 8'h3C);
    issue(OP_READ, 1, 0);
    issue(OP_CLEAR, 0, 8'hFF);
    issue(OP_CLEAR, 0, 0);

    // random: phases of growth, shrinkage and mixed traffic, a little noise
    random_start = sent;
    while (sent < random_start + RANDOM_ITEMS) begin
      if (!filled && sent > random_start + 300) begin
        // fill to capacity, then push past it and work at the tail
        filled = 1'b1;
        while (shadow.held < MAX_HELD) issue_valid(OP_INSERT);
        issue(OP_INSERT, MAX_HELD + 1, $urandom_range(0, 255));
        issue(OP_INSERT, 1, $urandom_range(0, 255));
        issue(OP_INSERT, 0, $urandom_range(0, 255));
        issue(OP_READ, MAX_HELD, 0);
        issue(OP_READ, MAX_HELD + 1, 0);
        issue(OP_DELETE, MAX_HELD + 1, 0);
        issue(OP_DELETE, MAX_HELD, 0);
        issue(OP_INSERT, MAX_HELD, $urandom_range(0, 255));
        issue(OP_DELETE, 1, 0);
      end
      if (left_in_phase == 0) begin
        tilt = tilt_t'($urandom_range(0, 2));
        no_gaps = ($urandom_range(0, 3) == 0);
        left_in_phase = $urandom_range(20, 60);
      end
      left_in_phase--;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        issue(op_t'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        roll = $urandom_range(0, 99);
        case (tilt)
          TILT_GROW: begin
            if (roll < 75) issue_valid(OP_INSERT);
            else if (roll < 85) issue_valid(OP_DELETE);
            else issue_valid(OP_READ);
          end
          TILT_SHRINK: begin
            if (roll < 15) issue_valid(OP_INSERT);
            else if (roll < 75) issue_valid(OP_DELETE);
            else issue_valid(OP_READ);
          end
          default: begin
            if (roll < 2) issue_valid(OP_CLEAR);
            else if (roll < 35) issue_valid(OP_INSERT);
            else if (roll < 68) issue_valid(OP_DELETE);
            else issue_valid(OP_READ);
          end
        endcase
      end
    end

    // drain the outstanding results, then watch for stray ones
    start = 1'b0;
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
